// ----- src/rwrsi_pkg.sv -----
// rwrsi_pkg: shared constants, state and control types for the rolling window rsi block
// no dependencies; used by every module under src
package rwrsi_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int PRICE_BITS_DEF = 32;

  localparam int PRICE_IN_W  = 32;
  localparam int S_TDATA_W   = 32;
  localparam int RSI_W       = 14;
  localparam int M_TDATA_W   = 16;
  localparam int WL_W        = 7;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [RSI_W-1:0] RSI_FULL  = 14'd10000;
  localparam logic [WL_W-1:0]  WL_RESET  = 7'd14;
  localparam logic             REG_WINDOW_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHG,
    ST_REM,
    ST_ADD,
    ST_CHK,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic chg;
    logic rem;
    logic add;
    logic chk;
    logic fin;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// ----- src/rwrsi_cell.sv -----
// rwrsi_cell: one stage of the change chain, holds one signed change as sign and magnitude
// depends on rwrsi_pkg; instantiated in a row by rolling_window_rsi_top
module rwrsi_cell #(
  parameter int W = rwrsi_pkg::PRICE_BITS_DEF + 1
) (
  input  logic         clk,
  input  logic         shift,
  input  logic         ins,
  input  logic [W-1:0] new_val,
  input  logic [W-1:0] nb_val,
  output logic [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= ins ? new_val : nb_val;
    end
  end

endmodule

// ----- src/rwrsi_div.sv -----
// rwrsi_div: restoring divider, one quotient bit per cycle, quotient known to fit rsi width
// depends on rwrsi_pkg
module rwrsi_div #(
  parameter int SUM_W = rwrsi_pkg::PRICE_BITS_DEF + 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rwrsi_pkg::div_ctl_t              ctl_in,
  input  logic [SUM_W+rwrsi_pkg::RSI_W-1:0] num,
  input  logic [SUM_W-1:0]                 den,
  output rwrsi_pkg::div_ctl_t              ctl_out,
  output logic [rwrsi_pkg::RSI_W-1:0]      quo
);

  localparam int QW    = rwrsi_pkg::RSI_W;
  localparam int NUM_W = SUM_W + QW;
  localparam int CNT_W = $clog2(QW + 1);

  logic [SUM_W-1:0] rem;
  logic [QW-1:0]    nlow;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;
  logic             qbit;

  assign trial = {rem, nlow[QW-1]};
  assign diff  = trial - {1'b0, den};
  assign qbit  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      rem  <= num[NUM_W-1:QW];
      nlow <= num[QW-1:0];
    end else if (busy) begin
      rem  <= qbit ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      nlow <= {nlow[QW-2:0], 1'b0};
      quo  <= {quo[QW-2:0], qbit};
    end
  end

  assign ctl_out.start = busy;
  assign ctl_out.done  = done;

endmodule

// ----- src/rolling_window_rsi_top.sv -----
// rolling_window_rsi_top: simple-average rsi over a rolling window of price changes
// depends on rwrsi_pkg, rwrsi_cell, rwrsi_div
//
// channel   dir  handshake         payload
// s_        in   tvalid/tready     tdata: close_price; tuser: start_series
// m_        out  tvalid/tready     tdata: rsi_hundredths (zero padded); tuser: window_full
// apb       in   psel/penable      window_length at byte address 0
//
// a request with a short result passes through the change, remove, add and check states,
// a series start goes from the change state straight to done, and a divided ratio adds the
// load state and the 14-step divider; a new request is taken only after the previous one finishes.
// the change chain moves one cell per price change, new changes enter at cell len-1.
// reset is synchronous; window_length returns to 14 and the window is empty.
// a stalled result holds in the output register and the block waits for it to drain.
module rolling_window_rsi_top #(
  parameter int MAX_WINDOW = rwrsi_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_BITS = rwrsi_pkg::PRICE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rwrsi_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] close_price
  input  logic                             s_tuser,   // [0] start_series
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rwrsi_pkg::M_TDATA_W-1:0]  m_tdata,   // [13:0] rsi_hundredths, [15:14] zero
  output logic                             m_tuser,   // [0] window_full
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rwrsi_pkg::ADDR_W-1:0]     paddr,
  input  logic [rwrsi_pkg::DATA_W-1:0]     pwdata,
  output logic [rwrsi_pkg::DATA_W-1:0]     prdata,
  output logic                             pready
);

  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int NUM_W  = SUM_W + rwrsi_pkg::RSI_W;
  localparam int CELL_W = PRICE_BITS + 1;

  rwrsi_pkg::state_t   state;
  rwrsi_pkg::state_t   state_next;
  rwrsi_pkg::ctl_t     ctl;
  rwrsi_pkg::div_ctl_t div_in;
  rwrsi_pkg::div_ctl_t div_out;

  logic [rwrsi_pkg::WL_W-1:0]  window_length;
  logic [LEN_W-1:0]            len;
  logic [LEN_W-1:0]            len_m1;
  logic                        cfg_wr;

  logic [PRICE_BITS-1:0]       price;
  logic                        start;
  logic [PRICE_BITS-1:0]       prev;
  logic [PRICE_BITS:0]         diff;
  logic                        chg_neg;
  logic [PRICE_BITS-1:0]       chg_mag;
  logic [SUM_W-1:0]            gain_sum;
  logic [SUM_W-1:0]            loss_sum;
  logic [LEN_W-1:0]            held;
  logic [NUM_W-1:0]            num;
  logic [SUM_W-1:0]            den;
  logic [rwrsi_pkg::RSI_W-1:0] quo;
  logic [rwrsi_pkg::RSI_W-1:0] res_val;
  logic                        res_full;
  logic                        full;
  logic                        out_free;

  logic [CELL_W-1:0]           cell_q [MAX_WINDOW];
  logic [CELL_W-1:0]           oldest;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rwrsi_pkg::REG_WINDOW_LENGTH);
  assign prdata = (paddr[2] == rwrsi_pkg::REG_WINDOW_LENGTH) ?
                  rwrsi_pkg::DATA_W'(window_length) : '0;

  always_comb begin
    if (window_length == '0) begin
      len = LEN_W'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = LEN_W'(window_length);
    end
  end
  assign len_m1 = len - LEN_W'(1);

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rwrsi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign full     = (held == len);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      rwrsi_pkg::ST_IDLE: if (s_tvalid) state_next = rwrsi_pkg::ST_CHG;
      rwrsi_pkg::ST_CHG:  state_next = start ? rwrsi_pkg::ST_DONE : rwrsi_pkg::ST_REM;
      rwrsi_pkg::ST_REM:  state_next = rwrsi_pkg::ST_ADD;
      rwrsi_pkg::ST_ADD:  state_next = rwrsi_pkg::ST_CHK;
      rwrsi_pkg::ST_CHK: begin
        state_next = (full && loss_sum != '0) ? rwrsi_pkg::ST_LOAD : rwrsi_pkg::ST_DONE;
      end
      rwrsi_pkg::ST_LOAD: state_next = rwrsi_pkg::ST_DIV;
      rwrsi_pkg::ST_DIV:  if (div_out.done) state_next = rwrsi_pkg::ST_DONE;
      rwrsi_pkg::ST_DONE: if (out_free) state_next = rwrsi_pkg::ST_IDLE;
      default:            state_next = rwrsi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    div_in.start = 1'b0;
    div_in.done  = 1'b0;
    s_tready     = 1'b0;
    case (state)
      rwrsi_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        ctl.take = s_tvalid;
      end
      rwrsi_pkg::ST_CHG:  ctl.chg = 1'b1;
      rwrsi_pkg::ST_REM:  ctl.rem = 1'b1;
      rwrsi_pkg::ST_ADD:  ctl.add = 1'b1;
      rwrsi_pkg::ST_CHK:  ctl.chk = 1'b1;
      rwrsi_pkg::ST_LOAD: div_in.start = 1'b1;
      rwrsi_pkg::ST_DIV:  ctl.fin = div_out.done;
      rwrsi_pkg::ST_DONE: ctl.fin = 1'b0;
      default:            ctl = '0;
    endcase
  end

  // price change as sign and magnitude
  assign diff = {1'b0, price} - {1'b0, prev};

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      price <= PRICE_BITS'(s_tdata);
      start <= s_tuser;
    end
    if (ctl.chg) begin
      chg_neg <= diff[PRICE_BITS];
      chg_mag <= diff[PRICE_BITS] ? PRICE_BITS'(-diff) : diff[PRICE_BITS-1:0];
    end
  end

  // window sums and fill count
  assign oldest = cell_q[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= rwrsi_pkg::WL_RESET;
      prev          <= '0;
      held          <= '0;
      gain_sum      <= '0;
      loss_sum      <= '0;
    end else if (cfg_wr) begin
      window_length <= pwdata[rwrsi_pkg::WL_W-1:0];
      held          <= '0;
      gain_sum      <= '0;
      loss_sum      <= '0;
    end else begin
      if (ctl.chg) begin
        prev <= price;
        if (start) begin
          held     <= '0;
          gain_sum <= '0;
          loss_sum <= '0;
        end
      end
      if (ctl.rem && full) begin
        held <= held - LEN_W'(1);
        if (oldest[PRICE_BITS]) begin
          loss_sum <= loss_sum - SUM_W'(oldest[PRICE_BITS-1:0]);
        end else begin
          gain_sum <= gain_sum - SUM_W'(oldest[PRICE_BITS-1:0]);
        end
      end
      if (ctl.add) begin
        held <= held + LEN_W'(1);
        if (chg_neg) begin
          loss_sum <= loss_sum + SUM_W'(chg_mag);
        end else begin
          gain_sum <= gain_sum + SUM_W'(chg_mag);
        end
      end
    end
  end

  // change chain
  for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
    logic [CELL_W-1:0] nb;
    if (gi == MAX_WINDOW - 1) begin : g_last
      assign nb = cell_q[gi];
    end else begin : g_mid
      assign nb = cell_q[gi+1];
    end
    rwrsi_cell #(.W(CELL_W)) u_cell (
      .clk     (clk),
      .shift   (ctl.add),
      .ins     (len_m1 == LEN_W'(gi)),
      .new_val ({chg_neg, chg_mag}),
      .nb_val  (nb),
      .q       (cell_q[gi])
    );
  end

  // ratio: floor(10000 * g / (g + l))
  always_ff @(posedge clk) begin
    if (ctl.chg && start) begin
      res_val  <= '0;
      res_full <= 1'b0;
    end
    if (ctl.chk) begin
      num <= (NUM_W'(gain_sum) << 13) + (NUM_W'(gain_sum) << 10) + (NUM_W'(gain_sum) << 9)
           + (NUM_W'(gain_sum) << 8) + (NUM_W'(gain_sum) << 4);
      den      <= gain_sum + loss_sum;
      res_full <= full;
      res_val  <= (full && loss_sum == '0) ? rwrsi_pkg::RSI_FULL : '0;
    end
    if (ctl.fin) begin
      res_val <= quo;
    end
  end

  rwrsi_div #(.SUM_W(SUM_W)) u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (div_in),
    .num     (num),
    .den     (den),
    .ctl_out (div_out),
    .quo     (quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == rwrsi_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rwrsi_pkg::ST_DONE && out_free) begin
      m_tdata <= rwrsi_pkg::M_TDATA_W'(res_val);
      m_tuser <= res_full;
    end
  end

endmodule

// ----- src/rwrsi_chk.sv -----
// rwrsi_chk: port-level checks on the rolling window rsi block, bound to the top level
// depends on rwrsi_pkg and rolling_window_rsi_top
module rwrsi_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [rwrsi_pkg::S_TDATA_W-1:0]  s_tdata,
  input logic                             s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [rwrsi_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic                             m_tuser,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [rwrsi_pkg::ADDR_W-1:0]     paddr,
  input logic [rwrsi_pkg::DATA_W-1:0]     pwdata,
  input logic [rwrsi_pkg::DATA_W-1:0]     prdata,
  input logic                             pready
);

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("result without a full window is not zero");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> rwrsi_pkg::RSI_W'(m_tdata) <= rwrsi_pkg::RSI_FULL &&
                 (m_tdata >> rwrsi_pkg::RSI_W) == '0)
    else $error("rsi out of range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in progress");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind rolling_window_rsi_top rwrsi_chk u_rwrsi_chk (.*);

// ----- sim/rolling_window_rsi_top_tb.sv -----
// rolling_window_rsi_top_tb: self-checking bench for the rolling window rsi block, with a
// directed table followed by random price series under random stalls on both streams
// depends on rwrsi_pkg and rolling_window_rsi_top from src
module rolling_window_rsi_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int SETTLE_CYCLES   = 30;
  localparam int PHASE_ITEMS     = 150;
  localparam int RING_DEPTH      = rwrsi_pkg::MAX_WINDOW_DEF;

  localparam int WL_W      = rwrsi_pkg::WL_W;
  localparam int RSI_W     = rwrsi_pkg::RSI_W;
  localparam int S_TDATA_W = rwrsi_pkg::S_TDATA_W;
  localparam int M_TDATA_W = rwrsi_pkg::M_TDATA_W;
  localparam int ADDR_W    = rwrsi_pkg::ADDR_W;
  localparam int DATA_W    = rwrsi_pkg::DATA_W;

  localparam logic [RSI_W-1:0] RSI_FULL = rwrsi_pkg::RSI_FULL;
  localparam logic [WL_W-1:0]  WL_RESET = rwrsi_pkg::WL_RESET;

  typedef enum logic { ROW_ITEM, ROW_WRITE } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [31:0]       price;
    logic              start;
    logic [WL_W-1:0]   wl;
    logic              typed;
    logic [RSI_W-1:0]  rsi;
    logic              full;
  } stim_row_t;

  typedef struct packed {
    logic [RSI_W-1:0] rsi;
    logic             full;
  } rsi_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // [31:0] close_price
  logic                  s_tuser = 1'b0; // [0] start_series
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;        // [13:0] rsi_hundredths, [15:14] zero
  logic                  m_tuser;        // [0] window_full
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  rolling_window_rsi_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rsi predictor state
  logic [WL_W-1:0]    wl_reg;
  logic [31:0]        prev_price;
  logic signed [32:0] change_ring [RING_DEPTH];
  logic [5:0]         ring_pos;
  logic [6:0]         changes_held;
  logic [37:0]        gain_sum;
  logic [37:0]        loss_sum;

  rsi_result_t rsi_results_due[$];
  stim_row_t   stim_rows[$];

  int mismatch_count = 0;
  int request_count = 0;
  int result_count = 0;
  int full_count = 0;
  int setting_count = 0;
  int idle_cycles = 0;
  int unsigned send_calm = 0;
  int unsigned recv_calm = 0;
  int unsigned recv_wait = 3;

  function automatic int unsigned window_span(input logic [WL_W-1:0] wl);
    if (wl == 0) return 1;
    if (wl > RING_DEPTH) return RING_DEPTH;
    return wl;
  endfunction

  task automatic clear_window();
    ring_pos = '0;
    changes_held = '0;
    gain_sum = '0;
    loss_sum = '0;
  endtask

  function automatic logic [32:0] magnitude(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  task automatic rsi_advance(input logic [31:0] price, input logic start,
                             output rsi_result_t res);
    logic signed [32:0] chg;
    logic signed [32:0] oldest;
    logic [5:0]         old_pos;
    logic [38:0]        total;
    logic [63:0]        scaled;
    int unsigned        span;
    span = window_span(wl_reg);
    res = '0;
    if (start) begin
      clear_window();
      prev_price = price;
    end else begin
      chg = $signed({1'b0, price}) - $signed({1'b0, prev_price});
      prev_price = price;
      if (changes_held >= span && changes_held > 0) begin
        old_pos = ring_pos - changes_held[5:0];
        oldest = change_ring[old_pos];
        if (oldest > 0) gain_sum = gain_sum - {5'd0, magnitude(oldest)};
        else loss_sum = loss_sum - {5'd0, magnitude(oldest)};
        changes_held = changes_held - 1;
      end
      change_ring[ring_pos] = chg;
      ring_pos = ring_pos + 1;
      changes_held = changes_held + 1;
      if (chg > 0) gain_sum = gain_sum + {5'd0, magnitude(chg)};
      else loss_sum = loss_sum + {5'd0, magnitude(chg)};
      if (changes_held == span) begin
        if (loss_sum == 0) begin
          res.rsi = RSI_FULL;
        end else begin
          total = {1'b0, gain_sum} + {1'b0, loss_sum};
          scaled = ({26'd0, gain_sum} * 64'd10000) / {25'd0, total};
          res.rsi = scaled[RSI_W-1:0];
        end
        res.full = 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < 40)
      $display("mismatch %s: got %0d, want %0d (result %0d, t=%0t)",
               what, got, want, result_count, $realtime);
    mismatch_count++;
  endtask

  function automatic int unsigned draw_pause(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // result side: random stalls and in-order compare
  always @(posedge clk) begin
    rsi_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (m_tuser) full_count++;
      if (rsi_results_due.size() == 0) begin
        report_mismatch("unexpected result, rsi", m_tdata[RSI_W-1:0], -1);
      end else begin
        want = rsi_results_due[0];
        rsi_results_due.delete(0);
        if (m_tdata[RSI_W-1:0] !== want.rsi)
          report_mismatch("rsi_hundredths", m_tdata[RSI_W-1:0], want.rsi);
        if (m_tuser !== want.full)
          report_mismatch("window_full", m_tuser, want.full);
        if (m_tdata[M_TDATA_W-1:RSI_W] !== '0)
          report_mismatch("tdata padding", m_tdata[M_TDATA_W-1:RSI_W], 0);
      end
      recv_wait = draw_pause(recv_calm);
      if (recv_wait != 0) m_tready <= 1'b0;
    end else if (!m_tready) begin
      if (recv_wait == 0) m_tready <= 1'b1;
      else recv_wait--;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_CYCLES);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [31:0] price, input logic start, input logic typed,
                           input logic [RSI_W-1:0] t_rsi, input logic t_full);
    int unsigned gap;
    rsi_result_t res;
    gap = draw_pause(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= price;
    s_tuser <= start;
    do @(posedge clk); while (!s_tready);
    rsi_advance(price, start, res);
    if (typed) begin
      res.rsi = t_rsi;
      res.full = t_full;
    end
    rsi_results_due.insert(rsi_results_due.size(), res);
    request_count++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (rsi_results_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_W'(rwrsi_pkg::REG_WINDOW_LENGTH) << 2;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_window(input logic [WL_W-1:0] wl);
    logic [DATA_W-1:0] rd;
    drain();
    apb_access(1'b1, {25'($urandom()), wl}, rd);
    wl_reg = wl;
    clear_window();
    setting_count++;
    apb_access(1'b0, '0, rd);
    if (rd[WL_W-1:0] !== wl) report_mismatch("window_length readback", rd[WL_W-1:0], wl);
  endtask

  task automatic add_item(input logic [31:0] price, input logic start, input logic typed,
                          input logic [RSI_W-1:0] rsi, input logic full);
    stim_row_t row;
    row = '{ROW_ITEM, price, start, '0, typed, rsi, full};
    stim_rows.insert(stim_rows.size(), row);
  endtask

  task automatic add_write(input logic [WL_W-1:0] wl);
    stim_row_t row;
    row = '{ROW_WRITE, '0, 1'b0, wl, 1'b0, '0, 1'b0};
    stim_rows.insert(stim_rows.size(), row);
  endtask

  // one series: a first price that is usually a start, then prices shaped by a random style
  task automatic run_series(input int unsigned steps);
    int unsigned style;
    longint      p;
    logic        start;
    style = $urandom_range(0, 5);
    p = $urandom();
    if (style == 2) p = $urandom_range(0, 1000);
    if (style == 3) p = 64'hFFFF_FFFF - $urandom_range(0, 1000);
    send_item(p[31:0], $urandom_range(0, 7) != 0, 1'b0, '0, 1'b0);
    for (int unsigned i = 0; i < steps; i++) begin
      case (style)
        0: p = p + longint'($urandom_range(0, 30)) - 15;
        1: p = p + longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        2: p = p + longint'($urandom_range(0, 100));
        3: p = p - longint'($urandom_range(0, 100));
        4: p = p;
        default: p = $urandom();
      endcase
      if (p < 0) p = 0;
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      start = (style == 5) && ($urandom_range(0, 15) == 0);
      send_item(p[31:0], start, 1'b0, '0, 1'b0);
    end
  endtask

  initial begin
    logic [WL_W-1:0] phase_lengths [10];
    int              phase_start;
    int unsigned     span;
    int              remaining;
    int unsigned     steps;
    wl_reg = WL_RESET;
    prev_price = '0;
    clear_window();

    // no start after reset, window lengths at and past both ends, flat and one-sided windows
    add_item(32'd100, 1'b0, 1'b1, '0, 1'b0);
    add_write(7'd1);
    add_item(32'hFFFF_FFFF, 1'b0, 1'b1, RSI_FULL, 1'b1);
    add_item(32'h0000_0000, 1'b0, 1'b1, '0, 1'b1);
    add_item(32'h0000_0000, 1'b0, 1'b1, RSI_FULL, 1'b1);
    add_item(32'd5, 1'b1, 1'b1, '0, 1'b0);
    add_item(32'd5, 1'b0, 1'b1, RSI_FULL, 1'b1);
    add_write(7'd0);
    add_item(32'd7, 1'b0, 1'b1, RSI_FULL, 1'b1);
    add_item(32'd3, 1'b0, 1'b1, '0, 1'b1);
    add_write(7'd2);
    add_item(32'd10, 1'b1, 1'b1, '0, 1'b0);
    add_item(32'd20, 1'b0, 1'b1, '0, 1'b0);
    add_item(32'd10, 1'b0, 1'b1, 14'd5000, 1'b1);
    add_item(32'd40, 1'b0, 1'b1, 14'd7500, 1'b1);
    add_item(32'd39, 1'b0, 1'b0, '0, 1'b0);
    add_write(7'd127);
    add_item(32'hFFFF_FFFF, 1'b1, 1'b1, '0, 1'b0);
    add_item(32'h0000_0000, 1'b0, 1'b1, '0, 1'b0);
    add_write(7'd3);
    add_item(32'd1, 1'b0, 1'b1, '0, 1'b0);
    add_item(32'h8000_0000, 1'b0, 1'b1, '0, 1'b0);
    add_item(32'h7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0);
    add_item(32'hAAAA_AAAA, 1'b1, 1'b1, '0, 1'b0);
    add_item(32'h5555_5555, 1'b0, 1'b1, '0, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0);
    add_item(32'h0000_0001, 1'b0, 1'b0, '0, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE)
        set_window(stim_rows[i].wl);
      else
        send_item(stim_rows[i].price, stim_rows[i].start, stim_rows[i].typed,
                  stim_rows[i].rsi, stim_rows[i].full);
    end

    phase_lengths = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd14, 7'd0, 7'd0, 7'd0, 7'd64};
    for (int ph = 6; ph < 9; ph++) begin
      if ($urandom_range(0, 3) == 0) phase_lengths[ph] = WL_W'($urandom_range(65, 127));
      else phase_lengths[ph] = WL_W'($urandom_range(1, 64));
    end

    foreach (phase_lengths[ph]) begin
      set_window(phase_lengths[ph]);
      span = window_span(wl_reg);
      phase_start = request_count;
      while (request_count - phase_start < PHASE_ITEMS) begin
        remaining = PHASE_ITEMS - (request_count - phase_start);
        steps = $urandom_range(span, 3 * span + 8);
        if (steps >= remaining) steps = remaining - 1;
        run_series(steps);
      end
    end

    drain();
    $display("sent %0d price requests over %0d window settings", request_count, setting_count);
    $display("checked %0d results, %0d with a full window", result_count, full_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
